### rtl/core/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies; used by every module under rtl/core.
package wbps_pkg;

	localparam int PATTERN_MAX = 32;
	localparam int PAT_REGS    = 4;
	localparam int REG_W       = 64;
	localparam int ADDR_W      = 64;
	localparam int LEN_W       = 6;
	localparam int IDX_W       = $clog2(PATTERN_MAX);
	localparam int CFG_IDX_W   = 3;
	localparam int Q_DEPTH     = 4;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

	typedef logic [PATTERN_MAX-1:0][7:0] byte_vec_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_ADDRESS = 3'd0,
		CFG_PATTERN_0    = 3'd1,
		CFG_PATTERN_1    = 3'd2,
		CFG_PATTERN_2    = 3'd3,
		CFG_PATTERN_3    = 3'd4,
		CFG_PATTERN_LEN  = 3'd5,
		CFG_FIRST_ONLY   = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              found;
		logic              last;
	} result_t;

	// Number of results pushed into the output queue for one item.
	typedef enum logic [1:0] {
		PUSH_NONE = 2'd0,
		PUSH_ONE  = 2'd1,
		PUSH_TWO  = 2'd2
	} push_cnt_t;

endpackage

### rtl/core/wildcard_byte_pattern_scan.sv
// Top level of the wildcard byte pattern scanner: config registers, window,
// one input stage and the result stage. Uses wbps_pkg, wbps_match, wbps_out_queue.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in_valid/in_ready    | data_byte, region_last
//   out     | out_valid/out_ready  | match_address, found, last
//
// One input byte per cycle while the queue has room. A byte is registered
// together with its window in the input stage; the window compare and
// address add then feed the result queue, from which results are taken.
// A byte with a match and region_last gives two results; the queue drains
// one per cycle while out_ready is high. Input stalls only when the queue
// holds more than two results. Reset clears registers, window and position count.
module wildcard_byte_pattern_scan (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wbps_pkg::REG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         data_byte,
	input  logic                               region_last,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [wbps_pkg::ADDR_W-1:0]        match_address,
	output logic                               found,
	output logic                               last
);

	logic [wbps_pkg::ADDR_W-1:0]                    base_q;
	logic [wbps_pkg::PAT_REGS-1:0][wbps_pkg::REG_W-1:0] pat_q;
	logic [wbps_pkg::LEN_W-1:0]                     plen_q;
	logic                                           first_only_q;

	wbps_pkg::byte_vec_t                window_q;
	logic [wbps_pkg::ADDR_W-1:0]        pos_q;
	logic                               first_done_q;

	logic                               valid_s1;
	wbps_pkg::byte_vec_t                win_s1;
	logic                               last_s1;
	logic                               enough_s1;
	logic [wbps_pkg::ADDR_W-1:0]        offset_s1;

	wbps_pkg::byte_vec_t                win_next;
	wbps_pkg::byte_vec_t                pattern;
	logic [wbps_pkg::LEN_W-1:0]         len_eff;
	logic [wbps_pkg::LEN_W-1:0]         len_m1;
	logic                               in_fire;
	logic                               adv_s1;
	logic                               hit;
	logic                               report;
	wbps_pkg::push_cnt_t                push_cnt;
	wbps_pkg::result_t                  push_data0;
	wbps_pkg::result_t                  push_data1;
	wbps_pkg::result_t                  match_res;
	wbps_pkg::result_t                  marker_res;
	wbps_pkg::result_t                  head_data;
	logic [wbps_pkg::Q_CNT_W-1:0]       q_count;

	assign cfg_ready = 1'b1;
	assign pattern   = pat_q;
	assign len_eff   = (plen_q > wbps_pkg::LEN_W'(wbps_pkg::PATTERN_MAX)) ?
		wbps_pkg::LEN_W'(wbps_pkg::PATTERN_MAX) : plen_q;
	assign len_m1    = len_eff - wbps_pkg::LEN_W'(1);
	assign win_next  = {data_byte, window_q[wbps_pkg::PATTERN_MAX-1:1]};

	// The first stage moves on whenever the queue can take two results.
	assign adv_s1   = valid_s1 && (q_count <= wbps_pkg::Q_CNT_W'(wbps_pkg::Q_DEPTH - 2));
	assign in_ready = !valid_s1 || adv_s1;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			pat_q        <= '0;
			plen_q       <= '0;
			first_only_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (wbps_pkg::cfg_idx_t'(cfg_index))
				wbps_pkg::CFG_BASE_ADDRESS: base_q       <= cfg_data;
				wbps_pkg::CFG_PATTERN_0:    pat_q[0]     <= cfg_data;
				wbps_pkg::CFG_PATTERN_1:    pat_q[1]     <= cfg_data;
				wbps_pkg::CFG_PATTERN_2:    pat_q[2]     <= cfg_data;
				wbps_pkg::CFG_PATTERN_3:    pat_q[3]     <= cfg_data;
				wbps_pkg::CFG_PATTERN_LEN:  plen_q       <= cfg_data[wbps_pkg::LEN_W-1:0];
				wbps_pkg::CFG_FIRST_ONLY:   first_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				if (region_last) begin
					window_q <= '0;
					pos_q    <= '0;
				end else begin
					window_q <= win_next;
					pos_q    <= pos_q + wbps_pkg::ADDR_W'(1);
				end
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	// pos_q counts bytes before this one, so the start offset is pos_q - (len - 1).
	always_ff @(posedge clk) begin
		if (in_fire) begin
			win_s1    <= win_next;
			last_s1   <= region_last;
			enough_s1 <= (pos_q >= wbps_pkg::ADDR_W'(len_m1)) && !(&pos_q);
			offset_s1 <= pos_q - wbps_pkg::ADDR_W'(len_m1);
		end
	end

	wbps_match u_match (
		.window  (win_s1),
		.pattern (pattern),
		.len     (len_eff),
		.hit     (hit)
	);

	assign report = hit && enough_s1 && (!first_only_q || !first_done_q);

	always_comb begin
		match_res.addr   = base_q + offset_s1;
		match_res.found  = 1'b1;
		match_res.last   = 1'b0;
		marker_res.addr  = '0;
		marker_res.found = 1'b0;
		marker_res.last  = 1'b1;
		push_data1       = marker_res;
		if (!adv_s1) begin
			push_cnt   = wbps_pkg::PUSH_NONE;
			push_data0 = match_res;
		end else if (report) begin
			push_cnt   = last_s1 ? wbps_pkg::PUSH_TWO : wbps_pkg::PUSH_ONE;
			push_data0 = match_res;
		end else begin
			push_cnt   = last_s1 ? wbps_pkg::PUSH_ONE : wbps_pkg::PUSH_NONE;
			push_data0 = marker_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_done_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				first_done_q <= 1'b0;
			end else if (report && first_only_q) begin
				first_done_q <= 1'b1;
			end
		end
	end

	wbps_out_queue u_out_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (push_cnt),
		.push_data0 (push_data0),
		.push_data1 (push_data1),
		.pop        (out_valid && out_ready),
		.head_data  (head_data),
		.not_empty  (out_valid),
		.count      (q_count)
	);

	assign match_address = head_data.addr;
	assign found         = head_data.found;
	assign last          = head_data.last;

`ifndef SYNTHESIS
	a_region_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && region_last |=> pos_q == '0 && window_q == '0)
		else $error("window or position not cleared after the last byte of a region");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(offset_s1) && $stable(last_s1))
		else $error("stalled first stage lost its item");
	a_first_only_single: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && first_only_q && first_done_q |-> !report)
		else $error("second match reported in first-only mode");
	a_marker_closes: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> !first_done_q)
		else $error("first-only flag survived the end of a region");
`endif

endmodule

### rtl/core/wbps_match.sv
// Window compare: checks the newest len bytes of the window against the pattern.
// Pattern byte 0 is literal, later zero bytes are wildcards. Uses wbps_pkg.
module wbps_match (
	input  wbps_pkg::byte_vec_t          window,
	input  wbps_pkg::byte_vec_t          pattern,
	input  logic [wbps_pkg::LEN_W-1:0]   len,
	output logic                         hit
);

	always_comb begin
		logic [wbps_pkg::LEN_W:0]   sum;
		logic [wbps_pkg::IDX_W-1:0] idx;
		logic [7:0]                 pb;
		logic                       ok;
		hit = (len != '0);
		for (int k = 0; k < wbps_pkg::PATTERN_MAX; k++) begin
			// Window slot k lines up with pattern index k + len - PATTERN_MAX.
			sum = (wbps_pkg::LEN_W + 1)'(k) + {1'b0, len};
			idx = wbps_pkg::IDX_W'(sum - (wbps_pkg::LEN_W + 1)'(wbps_pkg::PATTERN_MAX));
			pb  = pattern[idx];
			ok  = (pb == window[k]) || ((idx != '0) && (pb == 8'h00));
			if (sum >= (wbps_pkg::LEN_W + 1)'(wbps_pkg::PATTERN_MAX) && !ok) begin
				hit = 1'b0;
			end
		end
	end

endmodule

### rtl/core/wbps_out_queue.sv
// Small result queue that takes up to two results per cycle and gives one.
// Uses wbps_pkg for the result type and the depth constants.
module wbps_out_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wbps_pkg::push_cnt_t            push_cnt,
	input  wbps_pkg::result_t              push_data0,
	input  wbps_pkg::result_t              push_data1,
	input  logic                           pop,
	output wbps_pkg::result_t              head_data,
	output logic                           not_empty,
	output logic [wbps_pkg::Q_CNT_W-1:0]   count
);

	wbps_pkg::result_t                entry_q [wbps_pkg::Q_DEPTH];
	logic [wbps_pkg::Q_PTR_W-1:0]     head_q;
	logic [wbps_pkg::Q_PTR_W-1:0]     tail_q;
	logic [wbps_pkg::Q_CNT_W-1:0]     count_q;
	logic [wbps_pkg::Q_PTR_W-1:0]     tail_p1;
	logic [wbps_pkg::Q_CNT_W-1:0]     push_n;

	assign tail_p1   = tail_q + wbps_pkg::Q_PTR_W'(1);
	assign push_n    = wbps_pkg::Q_CNT_W'(push_cnt);
	assign head_data = entry_q[head_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + wbps_pkg::Q_PTR_W'(1);
			end
			tail_q  <= tail_q + wbps_pkg::Q_PTR_W'(push_n);
			count_q <= count_q + push_n - wbps_pkg::Q_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != wbps_pkg::PUSH_NONE) begin
			entry_q[tail_q] <= push_data0;
		end
		if (push_cnt == wbps_pkg::PUSH_TWO) begin
			entry_q[tail_p1] <= push_data1;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= wbps_pkg::Q_CNT_W'(wbps_pkg::Q_DEPTH))
		else $error("result queue overfilled");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("result queue popped while empty");
	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		!pop && push_cnt == wbps_pkg::PUSH_NONE |=> $stable(count_q) && $stable(head_q))
		else $error("result queue changed without a transfer");
`endif

endmodule

### dv/tb_wildcard_byte_pattern_scan.sv
// Self-checking testbench for wildcard_byte_pattern_scan: directed and random byte regions,
// with a match tracker class that predicts every report. Depends on wbps_pkg and the RTL.
`timescale 1ns / 100ps

module tb_wildcard_byte_pattern_scan;
	import wbps_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 950;

	// Predicts the reports of the scanner and holds them until they arrive.
	// New reports enter at the front of the queue, the oldest leave at the back.
	class match_tracker;
		logic [63:0]           base_addr;
		logic [PAT_REGS-1:0][63:0] pat_regs;
		logic [5:0]            pat_len;
		logic                  first_only_mode;
		logic [7:0]            window [PATTERN_MAX];
		logic [63:0]           position;
		logic                  first_seen;
		result_t               expected_reports [$];
		int                    errors;

		function new();
			base_addr = '0;
			pat_regs = '0;
			pat_len = '0;
			first_only_mode = 1'b0;
			foreach (window[i]) window[i] = 8'h00;
			position = '0;
			first_seen = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
			case (idx)
				CFG_BASE_ADDRESS: base_addr = value;
				CFG_PATTERN_0:    pat_regs[0] = value;
				CFG_PATTERN_1:    pat_regs[1] = value;
				CFG_PATTERN_2:    pat_regs[2] = value;
				CFG_PATTERN_3:    pat_regs[3] = value;
				CFG_PATTERN_LEN:  pat_len = value[5:0];
				CFG_FIRST_ONLY:   first_only_mode = value[0];
				default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, logic rlast);
			int      len;
			bit      hit;
			logic [7:0] pb;
			result_t r;
			for (int i = 0; i < PATTERN_MAX - 1; i++) window[i] = window[i+1];
			window[PATTERN_MAX-1] = b;
			position++;
			len = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
			hit = (len != 0) && (position >= len);
			for (int i = 0; i < len && hit; i++) begin
				pb = pat_regs[i/8][8*(i%8) +: 8];
				// The first pattern byte is always literal; later zero bytes match anything.
				if ((i == 0 || pb != 8'h00) && pb != window[PATTERN_MAX-len+i])
					hit = 0;
			end
			if (hit && !(first_only_mode && first_seen)) begin
				if (first_only_mode)
					first_seen = 1'b1;
				r.addr = base_addr + position - 64'(len);
				r.found = 1'b1;
				r.last = 1'b0;
				expected_reports.push_front(r);
			end
			if (rlast) begin
				r.addr = '0;
				r.found = 1'b0;
				r.last = 1'b1;
				expected_reports.push_front(r);
				position = '0;
				first_seen = 1'b0;
				foreach (window[i]) window[i] = 8'h00;
			end
		endfunction

		function void check_result(logic [63:0] a, logic f, logic l);
			result_t e;
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected result match_address=%h found=%b last=%b",
					$time, a, f, l);
				errors++;
				return;
			end
			e = expected_reports.pop_back();
			if (e.addr !== a) begin
				$display("%0t: match_address expected %h got %h", $time, e.addr, a);
				errors++;
			end
			if (e.found !== f) begin
				$display("%0t: found expected %b got %b", $time, e.found, f);
				errors++;
			end
			if (e.last !== l) begin
				$display("%0t: last expected %b got %b", $time, e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           data_byte = 8'h00;
	logic                 region_last = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [ADDR_W-1:0]    match_address;
	logic                 found;
	logic                 last;

	match_tracker tracker = new;
	int           cycle_count = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           items_sent = 0;
	int           act_len = 0;
	logic [7:0]   pat [PATTERN_MAX] = '{default: 8'h00};

	wildcard_byte_pattern_scan dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.region_last(region_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.match_address(match_address),
		.found(found),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				tracker.note_byte(data_byte, region_last);
			if (out_valid && out_ready)
				tracker.check_result(match_address, found, last);
		end
	end

	// All driving tasks start and end at a falling edge.
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_byte(logic [7:0] b, logic l);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		in_valid = 1'b1;
		data_byte = b;
		region_last = l;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Waits until every predicted report has been taken, then lets the pipeline drain.
	task automatic settle();
		while (tracker.expected_reports.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic program_scan(logic [63:0] base, int len_value, bit fo);
		logic [63:0] w;
		settle();
		cfg_write(CFG_BASE_ADDRESS, base);
		for (int r = 0; r < PAT_REGS; r++) begin
			for (int k = 0; k < 8; k++) w[8*k +: 8] = pat[8*r+k];
			cfg_write(CFG_IDX_W'(CFG_PATTERN_0 + r), w);
		end
		// Upper data bits are junk; only the low bits of these registers count.
		w = {$urandom, $urandom};
		w[5:0] = 6'(len_value);
		cfg_write(CFG_PATTERN_LEN, w);
		act_len = (w[5:0] > PATTERN_MAX) ? PATTERN_MAX : w[5:0];
		w = {$urandom, $urandom};
		w[0] = fo;
		cfg_write(CFG_FIRST_ONLY, w);
		cfg_write(CFG_UNUSED, {$urandom, $urandom});
	endtask

	// Random region bytes with copies of the active pattern planted in most regions.
	task automatic send_region(int n, bit close);
		logic [7:0] bytes_q [];
		int         off;
		bytes_q = new[n];
		for (int i = 0; i < n; i++)
			bytes_q[i] = ($urandom_range(3) == 0 && act_len > 0) ?
				pat[$urandom_range(act_len - 1)] : 8'($urandom_range(255));
		if (act_len > 0 && n >= act_len && $urandom_range(9) != 0) begin
			repeat ($urandom_range(1, 3)) begin
				off = $urandom_range(n - act_len);
				for (int i = 0; i < act_len; i++)
					if (i == 0 || pat[i] != 8'h00)
						bytes_q[off+i] = pat[i];
			end
		end
		for (int i = 0; i < n; i++)
			send_byte(bytes_q[i], close && i == n - 1);
		items_sent += n;
	endtask

	initial begin
		int phase;
		int len_value;
		int r;
		logic [63:0] base;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty pattern after reset gives only the end marker.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);

		// Literal zero first byte, a wildcard, and addresses that wrap past 2^64.
		pat[0] = 8'h00;
		pat[1] = 8'hAB;
		program_scan(64'hFFFF_FFFF_FFFF_FFFE, 3, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hAB, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hAB, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hAB, 1'b0);
		// Overlapping match completes on the closing byte: match plus marker.
		send_byte(8'h7F, 1'b1);
		// Region shorter than the pattern.
		send_byte(8'h00, 1'b0);
		send_byte(8'hAB, 1'b1);

		// First-only mode: one match per region, then a not-found region.
		program_scan(64'h0, 3, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hAB, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hAB, 1'b0);
		send_byte(8'h02, 1'b1);
		send_byte(8'hFF, 1'b1);

		// A length above the window size is clamped to the full window.
		program_scan(64'h1000, 40, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hAB, 1'b0);
		send_byte(8'hC3, 1'b1);

		phase = 0;
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			for (int i = 0; i < PATTERN_MAX; i++)
				pat[i] = ($urandom_range(99) < 35) ? 8'h00 : 8'($urandom_range(255));
			if ($urandom_range(4) == 0)
				pat[0] = 8'h00;
			r = $urandom_range(99);
			if (phase == 0)
				len_value = PATTERN_MAX;
			else if (phase == 1)
				len_value = 63;
			else if (r < 5)
				len_value = 0;
			else if (r < 60)
				len_value = $urandom_range(1, 6);
			else if (r < 85)
				len_value = $urandom_range(7, 16);
			else if (r < 95)
				len_value = $urandom_range(17, 32);
			else
				len_value = $urandom_range(33, 63);
			case ($urandom_range(3))
				0: base = 64'h0;
				1: base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(40));
				default: base = {$urandom, $urandom};
			endcase
			// A region left open by the previous phase sees the new settings mid-region.
			program_scan(base, len_value, 1'($urandom_range(1)));
			repeat ($urandom_range(3, 8)) begin
				send_region($urandom_range(1, act_len + 16), 1'b1);
				if ($urandom_range(7) == 0)
					settle();
			end
			if ($urandom_range(3) == 0)
				send_region($urandom_range(1, 10), 1'b0);
			phase++;
		end

		settle();
		repeat (20) @(negedge clk);
		if (tracker.errors == 0 && tracker.expected_reports.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
